[sv/irpfd_pkg.sv]
package irpfd_pkg;

	localparam int TICK_WIDTH   = 20;
	localparam int FRAME_BITS   = 16;
	localparam int NIBBLE_W     = 4;
	localparam int NIBBLES      = FRAME_BITS / NIBBLE_W;
	localparam int BIT_POS_W    = $clog2(FRAME_BITS);
	localparam int NUM_REGS     = 6;
	localparam int CFG_INDEX_W  = 3;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BIT_POS_W-1:0] BIT_POS_TOP = BIT_POS_W'(FRAME_BITS - 1);

	typedef logic [TICK_WIDTH-1:0] tick_t;
	typedef logic [NIBBLE_W-1:0]   nibble_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ONE_MIN   = 3'd0,
		REG_ONE_MAX   = 3'd1,
		REG_TWO_MIN   = 3'd2,
		REG_TWO_MAX   = 3'd3,
		REG_THREE_MIN = 3'd4,
		REG_THREE_MAX = 3'd5
	} reg_index_t;

	localparam tick_t ONE_MIN_RST   = TICK_WIDTH'(3000);
	localparam tick_t ONE_MAX_RST   = TICK_WIDTH'(7000);
	localparam tick_t TWO_MIN_RST   = TICK_WIDTH'(8000);
	localparam tick_t TWO_MAX_RST   = TICK_WIDTH'(12000);
	localparam tick_t THREE_MIN_RST = TICK_WIDTH'(13000);
	localparam tick_t THREE_MAX_RST = TICK_WIDTH'(17000);

	// pulse classes, in priority order
	typedef enum logic [1:0] {
		CLS_HEADER = 2'd0,
		CLS_ONE    = 2'd1,
		CLS_ZERO   = 2'd2,
		CLS_OTHER  = 2'd3
	} pulse_class_t;

	// one classified pulse waiting in the queue
	typedef struct packed {
		logic         valid;
		pulse_class_t cls;
	} queue_item_t;

	typedef struct packed {
		logic    header_active;
		logic    error_active;
		logic    frame_valid;
		logic    frame_bad;
		nibble_t robot_number;
		nibble_t speed_value;
		nibble_t status_value;
	} result_t;

endpackage

[sv/irpfd_front.sv]
module irpfd_front
	import irpfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  tick_t                  cfg_data,
	input  tick_t                  high_ticks,
	input  tick_t                  period_ticks,
	output pulse_class_t           cls
);

	tick_t one_min_q, one_max_q, two_min_q, two_max_q, three_min_q, three_max_q;
	logic  h1, h2, p2, p3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_min_q   <= ONE_MIN_RST;
			one_max_q   <= ONE_MAX_RST;
			two_min_q   <= TWO_MIN_RST;
			two_max_q   <= TWO_MAX_RST;
			three_min_q <= THREE_MIN_RST;
			three_max_q <= THREE_MAX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ONE_MIN:   one_min_q   <= cfg_data;
				REG_ONE_MAX:   one_max_q   <= cfg_data;
				REG_TWO_MIN:   two_min_q   <= cfg_data;
				REG_TWO_MAX:   two_max_q   <= cfg_data;
				REG_THREE_MIN: three_min_q <= cfg_data;
				REG_THREE_MAX: three_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// inclusive windows; an inverted window matches nothing
	assign h1 = (high_ticks   >= one_min_q)   && (high_ticks   <= one_max_q);
	assign h2 = (high_ticks   >= two_min_q)   && (high_ticks   <= two_max_q);
	assign p2 = (period_ticks >= two_min_q)   && (period_ticks <= two_max_q);
	assign p3 = (period_ticks >= three_min_q) && (period_ticks <= three_max_q);

	always_comb begin
		if (h1 && p2)
			cls = CLS_HEADER;
		else if (p3 && h2)
			cls = CLS_ONE;
		else if (p3 && h1)
			cls = CLS_ZERO;
		else
			cls = CLS_OTHER;
	end

endmodule

[sv/irpfd_queue.sv]
module irpfd_queue
	import irpfd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  pulse_class_t push_cls,
	output logic         not_full,
	input  logic         pop,
	output queue_item_t  head
);

	pulse_class_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign not_full   = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cls   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[sv/irpfd_back.sv]
module irpfd_back
	import irpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_item_t head,
	output logic        pop,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	logic [BIT_POS_W-1:0]  bit_pos_q, bit_pos_n;
	logic [FRAME_BITS-1:0] frame_q, frame_n, frame_upd;
	logic                  error_q, error_n, header_q, header_n;
	logic                  out_valid_q;
	result_t               res_q, res_n;
	nibble_t               sum;

	assign pop = head.valid && (!out_valid_q || res_ready);

	always_comb begin
		frame_upd            = frame_q;
		frame_upd[bit_pos_q] = (head.cls == CLS_ONE);
		sum = '0;
		for (int i = 0; i < NIBBLES; i++)
			sum = sum + frame_upd[i*NIBBLE_W +: NIBBLE_W];
	end

	always_comb begin
		bit_pos_n = bit_pos_q;
		frame_n   = frame_q;
		error_n   = error_q;
		header_n  = header_q;
		res_n     = '0;
		case (head.cls)
			CLS_HEADER: begin
				bit_pos_n = BIT_POS_TOP;
				header_n  = 1'b1;
				error_n   = 1'b0;
			end
			CLS_ONE, CLS_ZERO: begin
				if (!error_q) begin
					if (bit_pos_q == '0) begin
						// last bit: check the nibble sum and wait for a new header
						bit_pos_n = BIT_POS_TOP;
						frame_n   = '0;
						header_n  = 1'b0;
						error_n   = 1'b1;
						if (sum == '0) begin
							res_n.frame_valid  = 1'b1;
							res_n.robot_number = frame_upd[FRAME_BITS-1 -: NIBBLE_W];
							res_n.speed_value  = frame_upd[FRAME_BITS-1-NIBBLE_W -: NIBBLE_W];
							res_n.status_value = frame_upd[FRAME_BITS-1-2*NIBBLE_W -: NIBBLE_W];
						end else begin
							res_n.frame_bad = 1'b1;
						end
					end else begin
						bit_pos_n = bit_pos_q - 1'b1;
						frame_n   = frame_upd;
					end
				end else begin
					bit_pos_n = BIT_POS_TOP;
					frame_n   = '0;
					header_n  = 1'b0;
					error_n   = 1'b1;
				end
			end
			default: begin
				bit_pos_n = BIT_POS_TOP;
				frame_n   = '0;
				header_n  = 1'b0;
				error_n   = 1'b1;
			end
		endcase
		res_n.header_active = header_n;
		res_n.error_active  = error_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q   <= BIT_POS_TOP;
			frame_q     <= '0;
			error_q     <= 1'b1;
			header_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				bit_pos_q <= bit_pos_n;
				frame_q   <= frame_n;
				error_q   <= error_n;
				header_q  <= header_n;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res_n;
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule

[sv/ir_pulse_frame_decoder_core.sv]
// Path: a pulse accepted into the class queue is popped by the back end, which registers its result.
// Throughput: one pulse per cycle while out_ready stays high; while a result waits to be taken, the
// two-entry class queue takes up to two more beats before the input side stalls.
// Reset (arst_n low, asynchronous): queue empty, no result pending, windows back to their
// defaults, bit position at the top bit, frame cleared, error flag set, header flag clear.
module ir_pulse_frame_decoder_core
	import irpfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  tick_t                  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tick_t                  high_ticks,
	input  tick_t                  period_ticks,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   header_active,
	output logic                   error_active,
	output logic                   frame_valid,
	output logic                   frame_bad,
	output nibble_t                robot_number,
	output nibble_t                speed_value,
	output nibble_t                status_value
);

	pulse_class_t cls;
	queue_item_t  head;
	logic         not_full;
	logic         pop;
	result_t      res;

	// Front: hold the window registers and classify each pulse as it is accepted.
	irpfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.high_ticks   (high_ticks),
		.period_ticks (period_ticks),
		.cls          (cls)
	);

	// Accept a beat whenever the queue has a free slot.
	assign in_ready = not_full;

	irpfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && in_ready),
		.push_cls (cls),
		.not_full (not_full),
		.pop      (pop),
		.head     (head)
	);

	// Back: advance the frame state one class per cycle while the output is free, and register the result beat.
	irpfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign header_active = res.header_active;
	assign error_active  = res.error_active;
	assign frame_valid   = res.frame_valid;
	assign frame_bad     = res.frame_bad;
	assign robot_number  = res.robot_number;
	assign speed_value   = res.speed_value;
	assign status_value  = res.status_value;

	// A finished frame is either good or bad, never both.
	a_frame_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_valid && frame_bad))
		else $error("frame marked both valid and bad");

	// Frame end always drops the header and demands a new one.
	a_frame_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (frame_valid || frame_bad)) |-> (error_active && !header_active))
		else $error("frame end left header or error flag wrong");

	// Collecting bits and waiting for a header exclude each other.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(header_active && error_active))
		else $error("header and error flags both set");

	// Nibble fields stay zero unless the frame checked out.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_valid) |->
			(robot_number == '0 && speed_value == '0 && status_value == '0))
		else $error("frame fields nonzero without a valid frame");

	// A pending result is not lost: a stalled output beat stays valid.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");

endmodule
